// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file cbd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge, off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond in one cycle implies res in the next one.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

// ===== sv/cbd_pkg.sv =====
`default_nettype none

package cbd_pkg;

	localparam int SIZE_BITS_DEF   = 24;
	localparam int LENGTH_BITS_DEF = 32;
	localparam int MID_DEPTH_DEF   = 2;
	localparam int OUT_DEPTH_DEF   = 2;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	typedef enum logic [2:0] {
		ST_FRAME   = 3'd0,
		ST_DATA    = 3'd1,
		ST_DONE    = 3'd2,
		ST_ERROR   = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       body_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		status_t     status;
		logic [31:0] body_length;
	} out_item_t;

	// Byte after classification, as handed from front to back.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       body_start;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_ext;
		logic       is_cr;
		logic       is_lf;
	} cls_item_t;

endpackage

`default_nettype wire

// ===== sv/chunked_body_decoder.sv =====
// Chunked transfer decoder: one result per input byte, one byte per cycle sustained while neither side stalls.
// A byte accepted waits in the front queue until the back end takes it; its result then enters the result queue.
// Throughput is set by the phase update in the back end; the front queue
// and the result queue let either side stall without losing a byte.
// Reset (arst_n low, asynchronous): both queues empty, decoder at chunk-size start,
// totals zero.
`default_nettype none

module chunked_body_decoder import cbd_pkg::*; #(
	parameter int SIZE_BITS   = SIZE_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int MID_DEPTH   = MID_DEPTH_DEF,
	parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t item,
	output logic          full,
	output out_item_t     result,
	output logic          empty,
	input  wire logic     pop
);

	cls_item_t head;
	logic      head_empty;
	logic      take;

	cbd_front #(
		.MID_DEPTH(MID_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.take      (take),
		.head      (head),
		.head_empty(head_empty)
	);

	cbd_back #(
		.SIZE_BITS  (SIZE_BITS),
		.LENGTH_BITS(LENGTH_BITS),
		.OUT_DEPTH  (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_empty(head_empty),
		.take      (take),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

// ===== sv/cbd_fifo.sv =====
`default_nettype none

module cbd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/cbd_front.sv =====
`default_nettype none

module cbd_front import cbd_pkg::*; #(
	parameter int MID_DEPTH = MID_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire in_item_t  item,
	output logic           full,
	input  wire logic      take,
	output cls_item_t      head,
	output logic           head_empty
);

	cls_item_t              cls;
	logic [$bits(cls_item_t)-1:0] head_vec;

	always_comb begin
		cls            = '0;
		cls.in_byte    = item.in_byte;
		cls.body_start = item.body_start;
		cls.is_cr      = (item.in_byte == CH_CR);
		cls.is_lf      = (item.in_byte == CH_LF);
		cls.is_ext     = (item.in_byte == CH_SPACE) || (item.in_byte == CH_TAB) ||
		                 (item.in_byte == CH_SEMI);
		priority if (item.in_byte >= 8'h30 && item.in_byte <= 8'h39) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = item.in_byte[3:0];
		end else if ((item.in_byte >= 8'h61 && item.in_byte <= 8'h66) ||
		             (item.in_byte >= 8'h41 && item.in_byte <= 8'h46)) begin
			// letters a..f and A..F share the low three bits 1..6
			cls.is_hex  = 1'b1;
			cls.hex_val = item.in_byte[3:0] + 4'd9;
		end else begin
			cls.is_hex  = 1'b0;
			cls.hex_val = '0;
		end
	end

	cbd_fifo #(
		.WIDTH ($bits(cls_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (take),
		.rdata (head_vec),
		.empty (head_empty)
	);

	assign head = cls_item_t'(head_vec);

endmodule

`default_nettype wire

// ===== sv/cbd_back.sv =====
`default_nettype none

module cbd_back import cbd_pkg::*; #(
	parameter int SIZE_BITS   = SIZE_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cls_item_t head,
	input  wire logic      head_empty,
	output logic           take,
	output out_item_t      result,
	output logic           empty,
	input  wire logic      pop
);

	localparam int LEN_EXT = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

	typedef enum logic [12:0] {
		PH_SIZE_START = 13'b0000000000001,
		PH_SIZE       = 13'b0000000000010,
		PH_EXT        = 13'b0000000000100,
		PH_EXT_CR     = 13'b0000000001000,
		PH_DATA       = 13'b0000000010000,
		PH_DATA_CR    = 13'b0000000100000,
		PH_DATA_LF    = 13'b0000001000000,
		PH_TRL_START  = 13'b0000010000000,
		PH_TRL        = 13'b0000100000000,
		PH_TRL_CR     = 13'b0001000000000,
		PH_END_CR     = 13'b0010000000000,
		PH_DONE       = 13'b0100000000000,
		PH_ERROR      = 13'b1000000000000
	} phase_t;

	phase_t                 phase_q, ph, ph_n, after_line;
	logic [SIZE_BITS-1:0]   chunk_q, chunk, chunk_n, chunk_dec;
	logic [LENGTH_BITS-1:0] total_q, total, total_n;
	logic [LEN_EXT-1:0]     total_ext;
	status_t                st;
	logic [7:0]             obyte;
	logic                   out_full;
	out_item_t              res;
	logic [$bits(out_item_t)-1:0] res_vec;

	assign take = !head_empty && !out_full;

	always_comb begin
		// body_start clears everything before the byte is applied
		ph         = head.body_start ? PH_SIZE_START : phase_q;
		chunk      = head.body_start ? '0 : chunk_q;
		total      = head.body_start ? '0 : total_q;
		after_line = (chunk == '0) ? PH_TRL_START : PH_DATA;
		chunk_dec  = chunk - 1'b1;
		ph_n       = ph;
		chunk_n    = chunk;
		total_n    = total;
		st         = ST_FRAME;
		obyte      = '0;
		unique case (ph)
			PH_SIZE_START: begin
				if (head.is_hex) begin
					chunk_n = SIZE_BITS'(head.hex_val);
					ph_n    = PH_SIZE;
				end else begin
					ph_n = PH_ERROR;
					st   = ST_ERROR;
				end
			end
			PH_SIZE: begin
				priority if (head.is_hex) begin
					// overflow exactly when the top digit is already occupied
					if (chunk[SIZE_BITS-1 -: 4] != '0) begin
						ph_n = PH_ERROR;
						st   = ST_ERROR;
					end else begin
						chunk_n = {chunk[SIZE_BITS-5:0], head.hex_val};
					end
				end else if (head.is_ext) begin
					ph_n = PH_EXT;
				end else if (head.is_cr) begin
					ph_n = PH_EXT_CR;
				end else if (head.is_lf) begin
					ph_n = after_line;
				end else begin
					ph_n = PH_ERROR;
					st   = ST_ERROR;
				end
			end
			PH_EXT: begin
				priority if (head.is_cr) begin
					ph_n = PH_EXT_CR;
				end else if (head.is_lf) begin
					ph_n = after_line;
				end else begin
					ph_n = PH_EXT;
				end
			end
			PH_EXT_CR: begin
				if (head.is_lf) begin
					ph_n = after_line;
				end else begin
					ph_n = PH_ERROR;
					st   = ST_ERROR;
				end
			end
			PH_DATA: begin
				if (total == '1) begin
					ph_n = PH_ERROR;
					st   = ST_ERROR;
				end else begin
					total_n = total + 1'b1;
					obyte   = head.in_byte;
					st      = ST_DATA;
					chunk_n = chunk_dec;
					if (chunk_dec == '0) begin
						ph_n = PH_DATA_CR;
					end
				end
			end
			PH_DATA_CR: begin
				if (head.is_cr) begin
					ph_n = PH_DATA_LF;
				end else begin
					ph_n = PH_ERROR;
					st   = ST_ERROR;
				end
			end
			PH_DATA_LF: begin
				if (head.is_lf) begin
					ph_n = PH_SIZE_START;
				end else begin
					ph_n = PH_ERROR;
					st   = ST_ERROR;
				end
			end
			PH_TRL_START: begin
				priority if (head.is_cr) begin
					ph_n = PH_END_CR;
				end else if (head.is_lf) begin
					ph_n = PH_DONE;
					st   = ST_DONE;
				end else begin
					ph_n = PH_TRL;
				end
			end
			PH_TRL: begin
				priority if (head.is_cr) begin
					ph_n = PH_TRL_CR;
				end else if (head.is_lf) begin
					ph_n = PH_TRL_START;
				end else begin
					ph_n = PH_TRL;
				end
			end
			PH_TRL_CR: begin
				if (head.is_lf) begin
					ph_n = PH_TRL_START;
				end else begin
					ph_n = PH_ERROR;
					st   = ST_ERROR;
				end
			end
			PH_END_CR: begin
				if (head.is_lf) begin
					ph_n = PH_DONE;
					st   = ST_DONE;
				end else begin
					ph_n = PH_ERROR;
					st   = ST_ERROR;
				end
			end
			PH_DONE, PH_ERROR: begin
				st = ST_IGNORED;
			end
			default: begin
				st = ST_IGNORED;
			end
		endcase
		total_ext       = LEN_EXT'(total_n);
		res.out_byte    = obyte;
		res.status      = st;
		res.body_length = total_ext[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE_START;
			chunk_q <= '0;
			total_q <= '0;
		end else if (take) begin
			phase_q <= ph_n;
			chunk_q <= chunk_n;
			total_q <= total_n;
		end
	end

	cbd_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.rdata (res_vec),
		.empty (empty)
	);

	assign result = out_item_t'(res_vec);

endmodule

`default_nettype wire

// ===== sv/cbd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module cbd_checker import cbd_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire out_item_t result,
	input wire logic      empty,
	input wire logic      pop
);

	logic held;
	logic shows_data;

	assign held       = !empty && !pop;
	assign shows_data = !empty && (result.status == ST_DATA);

	// a waiting transaction stays put until it is popped
	`ASSERT_NEXT(a_result_hold, clk, arst_n, held, !empty && $stable(result), "result moved")

	`ASSERT_CLK(a_status_range, clk, arst_n, !empty |-> (result.status <= ST_IGNORED), "bad status")

	`ASSERT_CLK(a_byte_only_data, clk, arst_n, (!empty && !shows_data) |-> (result.out_byte == 8'h00), "stray byte")

	`ASSERT_CLK(a_data_counts, clk, arst_n, shows_data |-> (result.body_length != 32'd0), "zero length")

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.result(result),
	.empty (empty),
	.pop   (pop)
);

`default_nettype wire
